// ===== hw/rtl/lph_pkg.sv =====
// Package: types, codes and sizes for the linear probing hash table.
`timescale 1ns / 1ps

package lph_pkg;

    // Slot count is a power of two so the home slot is the low key bits.
    localparam int SLOT_W     = 4;
    localparam int TABLE_SIZE = 1 << SLOT_W;
    localparam int COUNT_W    = SLOT_W + 1;
    localparam int KEY_W      = 32;
    localparam int QTY_W      = 16;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_SEARCH = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INSERT,
        S_LOOKUP
    } state_t;

    typedef struct packed {
        action_t            action;
        logic [KEY_W-1:0]   part_key;
        logic [QTY_W-1:0]   quantity;
    } cmd_t;

    typedef struct packed {
        status_t            status;
        logic [QTY_W-1:0]   found_quantity;
        logic [SLOT_W-1:0]  slot_index;
        logic [COUNT_W-1:0] occupancy;
    } result_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [QTY_W-1:0]   qty;
    } entry_t;

endpackage

// ===== hw/rtl/linear_probe_hash_table.sv =====
// Top level: open addressing hash table with linear probing over one entry RAM.
`timescale 1ns / 1ps

//  channel   signals                  direction  beat
//  command   start, busy, cmd         in         start high while busy low
//  result    done, result             out        done high for one cycle
//
//  Insert walks the occupied flags one slot a cycle. Delete and search
//  stream reads of the entry RAM, one slot a cycle, and compare each slot
//  in the cycle after its read. Full, empty and no-op commands finish at
//  once. The result appears in the cycle after the command finishes.
//  Reset frees every slot at once through the occupied flags; no clearing pass.
//  The receiver cannot stall; a result is shown for one cycle only.

module linear_probe_hash_table (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  lph_pkg::cmd_t    cmd,
    output logic           done,
    output lph_pkg::result_t result
);
    import lph_pkg::*;

    state_t              state_reg, state_next;
    cmd_t                cmd_reg, cmd_next;
    logic [SLOT_W-1:0]   pos_reg, pos_next;
    logic [COUNT_W-1:0]  probe_cnt_reg, probe_cnt_next;
    logic                cmp_valid_reg, cmp_valid_next;
    logic [SLOT_W-1:0]   cmp_slot_reg, cmp_slot_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [TABLE_SIZE-1:0] occ_reg, occ_next;
    logic                done_reg, done_next;
    result_t             result_reg, result_next;

    entry_t              mem [TABLE_SIZE];
    entry_t              rd_entry_reg;
    logic                rd_en;
    logic                wr_en;

    logic                probe_hit;
    logic                probe_end;
    logic                insert_stop;

    assign rd_en       = (state_reg == S_LOOKUP) && (probe_cnt_reg < COUNT_W'(TABLE_SIZE));
    assign wr_en       = (state_reg == S_INSERT) && !occ_reg[pos_reg];
    assign probe_hit   = cmp_valid_reg && occ_reg[cmp_slot_reg]
                         && (rd_entry_reg.key == cmd_reg.part_key);
    assign probe_end   = cmp_valid_reg && (probe_cnt_reg == COUNT_W'(TABLE_SIZE));
    assign insert_stop = !occ_reg[pos_reg]
                         || (probe_cnt_reg == COUNT_W'(TABLE_SIZE - 1));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[pos_reg] <= '{key: cmd_reg.part_key, qty: cmd_reg.quantity};
        end
        if (rd_en)
        begin
            rd_entry_reg <= mem[pos_reg];
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (cmd.action)
                        ACT_INSERT:
                        begin
                            if (count_reg != COUNT_W'(TABLE_SIZE))
                            begin
                                state_next = S_INSERT;
                            end
                        end
                        ACT_DELETE, ACT_SEARCH:
                        begin
                            if (count_reg != '0)
                            begin
                                state_next = S_LOOKUP;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_INSERT:
            begin
                if (insert_stop)
                begin
                    state_next = S_IDLE;
                end
            end
            S_LOOKUP:
            begin
                if (probe_hit || probe_end)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and result
    always_comb
    begin
        cmd_next       = cmd_reg;
        pos_next       = pos_reg;
        probe_cnt_next = probe_cnt_reg;
        cmp_valid_next = 1'b0;
        cmp_slot_next  = cmp_slot_reg;
        count_next     = count_reg;
        occ_next       = occ_reg;
        done_next      = 1'b0;
        result_next    = result_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next       = cmd;
                    pos_next       = cmd.part_key[SLOT_W-1:0];
                    probe_cnt_next = '0;
                    result_next    = '{status: ST_DONE, found_quantity: '0,
                                       slot_index: '0, occupancy: count_reg};
                    case (cmd.action)
                        ACT_INSERT:
                        begin
                            if (count_reg == COUNT_W'(TABLE_SIZE))
                            begin
                                result_next.status = ST_FULL;
                                done_next          = 1'b1;
                            end
                        end
                        ACT_DELETE:
                        begin
                            if (count_reg == '0)
                            begin
                                result_next.status = ST_EMPTY;
                                done_next          = 1'b1;
                            end
                        end
                        ACT_SEARCH:
                        begin
                            if (count_reg == '0)
                            begin
                                result_next.status = ST_NOT_FOUND;
                                done_next          = 1'b1;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_INSERT:
            begin
                if (!occ_reg[pos_reg])
                begin
                    occ_next[pos_reg] = 1'b1;
                    count_next        = count_reg + 1'b1;
                    result_next       = '{status: ST_DONE, found_quantity: '0,
                                          slot_index: pos_reg,
                                          occupancy: count_reg + 1'b1};
                    done_next         = 1'b1;
                end
                else if (insert_stop)
                begin
                    result_next = '{status: ST_FULL, found_quantity: '0,
                                    slot_index: '0, occupancy: count_reg};
                    done_next   = 1'b1;
                end
                else
                begin
                    pos_next       = pos_reg + 1'b1;
                    probe_cnt_next = probe_cnt_reg + 1'b1;
                end
            end
            S_LOOKUP:
            begin
                // Issue the next read while comparing the previous one.
                if (rd_en)
                begin
                    pos_next       = pos_reg + 1'b1;
                    probe_cnt_next = probe_cnt_reg + 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_slot_next  = pos_reg;
                end
                if (probe_hit)
                begin
                    cmp_valid_next = 1'b0;
                    done_next      = 1'b1;
                    result_next    = '{status: ST_DONE, found_quantity: '0,
                                       slot_index: cmp_slot_reg, occupancy: count_reg};
                    if (cmd_reg.action == ACT_DELETE)
                    begin
                        occ_next[cmp_slot_reg] = 1'b0;
                        count_next             = count_reg - 1'b1;
                        result_next.occupancy  = count_reg - 1'b1;
                    end
                    else
                    begin
                        result_next.found_quantity = rd_entry_reg.qty;
                    end
                end
                else if (probe_end)
                begin
                    cmp_valid_next = 1'b0;
                    done_next      = 1'b1;
                    result_next    = '{status: ST_NOT_FOUND, found_quantity: '0,
                                       slot_index: '0, occupancy: count_reg};
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            probe_cnt_reg <= '0;
            cmp_valid_reg <= 1'b0;
            count_reg     <= '0;
            occ_reg       <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            probe_cnt_reg <= probe_cnt_next;
            cmp_valid_reg <= cmp_valid_next;
            count_reg     <= count_next;
            occ_reg       <= occ_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        pos_reg      <= pos_next;
        cmp_slot_reg <= cmp_slot_next;
        result_reg   <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    a_count_matches_flags: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) == 32'($countones(occ_reg)))
        else $error("entry count differs from occupied flags");

    a_done_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("result beat while a command is still probing");

    a_write_marks_slot: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> occ_reg[$past(pos_reg)])
        else $error("written slot not marked occupied");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && result_reg.status == ST_FULL)
            |-> (result_reg.occupancy == COUNT_W'(TABLE_SIZE)))
        else $error("table full reported below capacity");

    a_hit_occupied: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOOKUP && probe_hit) |-> cmp_valid_reg)
        else $error("hit taken without a valid read");

endmodule

// ===== tb/tb.sv =====
// Testbench for the linear probing hash table: random command traffic checked against a predictor.
`timescale 1ns / 1ps

module tb;

    import lph_pkg::*;

    localparam int CYCLE_LIMIT  = 200_000;
    localparam int SETTLE_CYCLES = 24;
    localparam int EPISODES     = 14;
    localparam int EPISODE_LEN  = 40;

    typedef struct packed {
        cmd_t c;
        logic drain_first;
    } pending_cmd_t;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    logic    busy;
    cmd_t    cmd = '0;
    logic    done;
    result_t result;

    linear_probe_hash_table dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    // Shadow copy of the table
    logic [KEY_W-1:0] slot_key [TABLE_SIZE];
    logic [QTY_W-1:0] slot_qty [TABLE_SIZE];
    logic             slot_used [TABLE_SIZE];
    int               live_count = 0;

    pending_cmd_t cmd_queue[$];
    result_t      expected_results[$];

    int error_count = 0;
    int cycle_count = 0;
    int gap_left    = 0;
    int burst_left  = 0;
    int peak_count  = 0;
    int n_by_action [4];
    int n_by_status [4];

    pending_cmd_t beat;
    result_t      predicted;
    result_t      oldest_expected;

    initial begin
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            slot_used[i] = 1'b0;
            slot_key[i]  = '0;
            slot_qty[i]  = '0;
        end
        for (int i = 0; i < 4; i++)
        begin
            n_by_action[i] = 0;
            n_by_status[i] = 0;
        end
    end

    initial begin
        forever #5 clk = ~clk;
    end

    // First occupied slot holding key, probing from its home slot; -1 if absent
    function automatic int find_key(logic [KEY_W-1:0] key);
        int pos;
        int n;
        int hit;
        pos = key % TABLE_SIZE;
        hit = -1;
        for (n = 0; n < TABLE_SIZE && hit < 0; n++)
        begin
            if (slot_used[pos] && slot_key[pos] == key)
                hit = pos;
            else
                pos = (pos + 1) % TABLE_SIZE;
        end
        return hit;
    endfunction

    // Apply one command to the shadow table and return the result it must produce
    function automatic result_t apply_command(cmd_t c);
        result_t r;
        int      pos;
        int      n;
        int      hit;
        r        = '0;
        r.status = ST_DONE;
        hit      = -1;
        case (c.action)
            ACT_INSERT:
            begin
                if (live_count >= TABLE_SIZE)
                    r.status = ST_FULL;
                else
                begin
                    pos = c.part_key % TABLE_SIZE;
                    for (n = 0; n < TABLE_SIZE && hit < 0; n++)
                    begin
                        if (!slot_used[pos])
                            hit = pos;
                        else
                            pos = (pos + 1) % TABLE_SIZE;
                    end
                    if (hit < 0)
                        r.status = ST_FULL;
                    else
                    begin
                        slot_used[hit] = 1'b1;
                        slot_key[hit]  = c.part_key;
                        slot_qty[hit]  = c.quantity;
                        live_count++;
                        r.slot_index = SLOT_W'(hit);
                    end
                end
            end
            ACT_DELETE:
            begin
                if (live_count == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    hit = find_key(c.part_key);
                    if (hit < 0)
                        r.status = ST_NOT_FOUND;
                    else
                    begin
                        slot_used[hit] = 1'b0;
                        live_count--;
                        r.slot_index = SLOT_W'(hit);
                    end
                end
            end
            ACT_SEARCH:
            begin
                hit = (live_count == 0) ? -1 : find_key(c.part_key);
                if (hit < 0)
                    r.status = ST_NOT_FOUND;
                else
                begin
                    r.found_quantity = slot_qty[hit];
                    r.slot_index     = SLOT_W'(hit);
                end
            end
            default:
            begin
                // unused code: no operation
            end
        endcase
        r.occupancy = COUNT_W'(live_count);
        return r;
    endfunction

    task automatic queue_cmd(logic [1:0] act, logic [KEY_W-1:0] key,
                             logic [QTY_W-1:0] qty, logic drain);
        pending_cmd_t p;
        p.c.action      = action_t'(act);
        p.c.part_key    = key;
        p.c.quantity    = qty;
        p.drain_first   = drain;
        cmd_queue.push_back(p);
    endtask

    // Driver: bursts of commands with random gaps; hold a command until accepted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start      <= 1'b0;
            gap_left   <= 0;
            burst_left <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                beat      = cmd_queue.pop_front();
                predicted = apply_command(beat.c);
                expected_results.push_back(predicted);
                n_by_action[beat.c.action]++;
                n_by_status[predicted.status]++;
                if (live_count > peak_count)
                    peak_count = live_count;
            end
            if (!(start && busy))
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    start    <= 1'b0;
                end
                else if (cmd_queue.size() == 0 ||
                         (cmd_queue[0].drain_first && expected_results.size() != 0))
                    start <= 1'b0;
                else
                begin
                    start <= 1'b1;
                    cmd   <= cmd_queue[0].c;
                    if (burst_left <= 1)
                    begin
                        if ($urandom_range(0, 3) == 0)
                        begin
                            // long stretch with no idling
                            burst_left <= $urandom_range(20, 40);
                            gap_left   <= 0;
                        end
                        else
                        begin
                            burst_left <= $urandom_range(1, 10);
                            gap_left   <= ($urandom_range(0, 3) == 0) ?
                                          $urandom_range(8, 20) : $urandom_range(1, 4);
                        end
                    end
                    else
                        burst_left <= burst_left - 1;
                end
            end
        end
    end

    // Monitor: every done beat must match the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result beat with no command outstanding");
                error_count++;
            end
            else
            begin
                oldest_expected = expected_results.pop_front();
                if (result.status !== oldest_expected.status)
                begin
                    $error("status: expected %0d, got %0d",
                           oldest_expected.status, result.status);
                    error_count++;
                end
                if (result.found_quantity !== oldest_expected.found_quantity)
                begin
                    $error("found_quantity: expected %0d, got %0d",
                           oldest_expected.found_quantity, result.found_quantity);
                    error_count++;
                end
                if (result.slot_index !== oldest_expected.slot_index)
                begin
                    $error("slot_index: expected %0d, got %0d",
                           oldest_expected.slot_index, result.slot_index);
                    error_count++;
                end
                if (result.occupancy !== oldest_expected.occupancy)
                begin
                    $error("occupancy: expected %0d, got %0d",
                           oldest_expected.occupancy, result.occupancy);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        logic [KEY_W-1:0] pool [16];
        int               base;
        int               spread;
        int               pool_n;
        int               mode;
        int               roll;
        int               w_insert;
        int               w_delete;
        logic [1:0]       act;
        logic [KEY_W-1:0] key;

        // Directed: empty table, no-op, wrap-around, duplicates, no tombstones
        queue_cmd(ACT_SEARCH, 32'h0000_0000, 16'h0000, 1'b0);
        queue_cmd(ACT_DELETE, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
        queue_cmd(2'd3,       32'hFFFF_FFFF, 16'hFFFF, 1'b0);
        queue_cmd(ACT_INSERT, 32'h0000_0000, 16'h0000, 1'b0);
        queue_cmd(ACT_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
        queue_cmd(ACT_INSERT, 32'h0000_001F, 16'hA5A5, 1'b0);
        queue_cmd(ACT_INSERT, 32'h0000_0000, 16'h1234, 1'b0);
        queue_cmd(ACT_SEARCH, 32'h0000_0000, 16'hFFFF, 1'b0);
        queue_cmd(ACT_SEARCH, 32'h0000_001F, 16'h0000, 1'b0);
        queue_cmd(ACT_SEARCH, 32'h0000_0005, 16'h0000, 1'b0);
        queue_cmd(ACT_DELETE, 32'h0000_0000, 16'h0000, 1'b0);
        queue_cmd(ACT_SEARCH, 32'h0000_0000, 16'h0000, 1'b0);
        queue_cmd(ACT_DELETE, 32'h1234_5670, 16'h0000, 1'b0);
        // fill the remaining 13 slots, then hit the full table
        for (int i = 0; i < 13; i++)
            queue_cmd(ACT_INSERT, 32'h8000_0000 | (i * 7), 16'(i * 4099), 1'b0);
        queue_cmd(ACT_INSERT, 32'h5555_5555, 16'h5555, 1'b0);
        queue_cmd(ACT_SEARCH, 32'hAAAA_AAAA, 16'h0000, 1'b0);
        queue_cmd(2'd3,       32'h0000_0000, 16'h0000, 1'b0);

        // Random episodes: clustered key pools, with fill, mixed and drain phases
        for (int ep = 0; ep < EPISODES; ep++)
        begin
            base   = $urandom_range(0, TABLE_SIZE - 1);
            spread = $urandom_range(0, TABLE_SIZE - 1);
            pool_n = $urandom_range(3, 14);
            mode   = ep % 3;
            for (int i = 0; i < pool_n; i++)
                pool[i] = ($urandom() & ~(TABLE_SIZE - 1)) |
                          ((base + $urandom_range(0, spread)) % TABLE_SIZE);
            w_insert = (mode == 0) ? 60 : (mode == 1) ? 35 : 15;
            w_delete = (mode == 0) ? 15 : (mode == 1) ? 30 : 50;
            for (int i = 0; i < EPISODE_LEN; i++)
            begin
                roll = $urandom_range(0, 99);
                key  = pool[$urandom_range(0, pool_n - 1)];
                if ($urandom_range(0, 99) < 6)
                begin
                    // noise: unused code or an unrelated key
                    act = ($urandom_range(0, 1) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
                    key = $urandom();
                end
                else if (roll < w_insert)
                    act = ACT_INSERT;
                else if (roll < w_insert + w_delete)
                    act = ACT_DELETE;
                else
                    act = ACT_SEARCH;
                queue_cmd(act, key, 16'($urandom_range(0, 65535)),
                          (i == 0) && (ep % 4 == 2));
            end
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        @(posedge clk);
        while (cmd_queue.size() != 0 || start)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Ran %0d inserts, %0d deletes, %0d searches, %0d no-ops; peak occupancy %0d.",
                 n_by_action[ACT_INSERT], n_by_action[ACT_DELETE],
                 n_by_action[ACT_SEARCH], n_by_action[3], peak_count);
        $display("Outcomes: %0d done/found, %0d not found, %0d table full, %0d table empty.",
                 n_by_status[ST_DONE], n_by_status[ST_NOT_FOUND],
                 n_by_status[ST_FULL], n_by_status[ST_EMPTY]);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
